### sv/tpcs_pkg.sv
// shared constants, register codes and types of the touch point calibrate and settle unit
package tpcs_pkg;

  // field widths
  localparam int RAW_W       = 12;
  localparam int THR_W       = 7;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 40;

  // defaults of the top level parameters
  localparam int DEF_SCREEN_WIDTH  = 320;
  localparam int DEF_SCREEN_HEIGHT = 240;
  localparam int DEF_EDGE_MARGIN   = 24;

  // mapping and settle rules
  localparam int MIN_SPAN    = 100;
  localparam int SETTLE_TOL  = 18;
  localparam int SETTLE_NEED = 3;

  // sum / 3 as (sum * RECIP3) >> RECIP3_SHIFT, exact for sums below 2**15
  localparam int RECIP3       = 21846;
  localparam int RECIP3_SHIFT = 16;

  // shared multiplier operand widths, cover every legal screen size
  localparam int MUL_A_W = 14;
  localparam int MUL_B_W = 15;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_RIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_TOP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CAL_BOTTOM = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PRESS_THR  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_FLIP       = 3'd5;

  // register reset values
  localparam logic [RAW_W-1:0] RST_CAL_LO    = 12'd0;
  localparam logic [RAW_W-1:0] RST_CAL_HI    = 12'd4095;
  localparam logic [THR_W-1:0] RST_PRESS_THR = 7'd120;

  typedef struct packed {
    logic [RAW_W-1:0] cal_left;
    logic [RAW_W-1:0] cal_right;
    logic [RAW_W-1:0] cal_top;
    logic [RAW_W-1:0] cal_bottom;
    logic [THR_W-1:0] press_thr;
    logic             flip;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### sv/tpcs_cfg.sv
// configuration register file with write decode
module tpcs_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tpcs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tpcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output tpcs_pkg::cfg_t                 cfg_o
);
  import tpcs_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CAL_LEFT:   cfg_d.cal_left   = cfg_wdata_i[RAW_W-1:0];
        REG_CAL_RIGHT:  cfg_d.cal_right  = cfg_wdata_i[RAW_W-1:0];
        REG_CAL_TOP:    cfg_d.cal_top    = cfg_wdata_i[RAW_W-1:0];
        REG_CAL_BOTTOM: cfg_d.cal_bottom = cfg_wdata_i[RAW_W-1:0];
        REG_PRESS_THR:  cfg_d.press_thr  = cfg_wdata_i[THR_W-1:0];
        REG_FLIP:       cfg_d.flip       = cfg_wdata_i[0];
        default:        cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_left   <= RST_CAL_LO;
      cfg_q.cal_right  <= RST_CAL_HI;
      cfg_q.cal_top    <= RST_CAL_LO;
      cfg_q.cal_bottom <= RST_CAL_HI;
      cfg_q.press_thr  <= RST_PRESS_THR;
      cfg_q.flip       <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/tpcs_div.sv
// shared serial unsigned divider, two quotient bits per cycle
module tpcs_div #(
  parameter int DW  = 22,
  parameter int DVW = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DW-1:0]         dividend_i,
  input  logic [DVW-1:0]        divisor_i,
  output logic [DW-1:0]         quotient_o,
  output tpcs_pkg::div_stat_t   stat_o
);
  import tpcs_pkg::*;

  localparam int STEPS = DW / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [DW-1:0]  num_q, num_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DVW-1:0] dvs_q;
  logic [CW-1:0]  cnt_q;
  logic           busy_q;
  logic           done_q;

  // two restoring steps, quotient bits shift in at the bottom of num
  always_comb begin
    logic [DVW:0] sh;
    num_d = num_q;
    rem_d = rem_q;
    sh    = '0;
    for (int k = 0; k < 2; k++) begin
      sh    = {rem_d, num_d[DW-1]};
      num_d = {num_d[DW-2:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        sh       = sh - {1'b0, dvs_q};
        num_d[0] = 1'b1;
      end
      rem_d = sh[DVW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o  = num_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("divider not busy after start");
  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CW'(1)) |=> (done_q && !busy_q))
    else $error("divider did not finish after last step");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while busy");

endmodule

### sv/touch_point_calibrate_and_settle_unit.sv
// touch point calibrate and settle unit: sequencer, shared multiplier and settle filter
// a release, a held contact or a weak sample goes straight to the output state; a qualifying
// sample runs the shared serial divider once per axis, then the settle step and, when it
// completes the settle run, the averaging pass; one sample is in work at a time
// the output register frees the input side while a result waits to be taken
// reset (asynchronous, active low) clears the sequencer, settle state, latched point and
// registers to their reset values; there is no clearing pass
module touch_point_calibrate_and_settle_unit #(
  parameter int SCREEN_WIDTH  = tpcs_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = tpcs_pkg::DEF_SCREEN_HEIGHT,
  parameter int EDGE_MARGIN   = tpcs_pkg::DEF_EDGE_MARGIN,
  localparam int XW           = $clog2(SCREEN_WIDTH),
  localparam int YW           = $clog2(SCREEN_HEIGHT),
  localparam int OUT_TDATA_W  = ((XW + YW + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // raw_x, raw_y, raw_pressure
  input  logic [tpcs_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // touched
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x, pos_y
  output logic [OUT_TDATA_W-1:0]          m_axis_tdata,
  // point_valid
  output logic                            m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_we_i,
  input  logic [tpcs_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [tpcs_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tpcs_pkg::*;

  localparam int MAXS = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
  localparam int DW0  = RAW_W + $clog2(MAXS);
  localparam int DW   = DW0 + (DW0 % 2);
  localparam int VW   = DW + 2;
  localparam int MW   = (XW > YW) ? XW : YW;
  localparam int SXW  = $clog2(SETTLE_NEED * SCREEN_WIDTH);
  localparam int SYW  = $clog2(SETTLE_NEED * SCREEN_HEIGHT);
  localparam int TX   = SCREEN_WIDTH - 1 - 2 * EDGE_MARGIN;
  localparam int TY   = SCREEN_HEIGHT - 1 - 2 * EDGE_MARGIN;
  localparam int PRW  = MUL_A_W + MUL_B_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_DGO  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_CMP  = 3'd4;
  localparam logic [2:0] S_AMUL = 3'd5;
  localparam logic [2:0] S_AVG  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  cfg_t      cfg;
  div_stat_t div_stat;
  logic [DW-1:0] quot;

  // control state
  logic [2:0]     state_q, state_d;
  logic           axis_q, axis_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [SXW-1:0] sum_x_q, sum_x_d;
  logic [SYW-1:0] sum_y_q, sum_y_d;
  logic           reported_q, reported_d;
  logic [XW-1:0]  held_x_q, held_x_d;
  logic [YW-1:0]  held_y_q, held_y_d;
  logic           m_valid_q, m_valid_d;

  // payload
  logic [RAW_W-1:0] raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic [PRW-1:0]   prod_q, prod_d;
  logic             neg_q, neg_d, narrow_q, narrow_d;
  logic [RAW_W-1:0] divisor_q, divisor_d;
  logic [XW-1:0]    mx_q, mx_d, sx_q, sx_d;
  logic [YW-1:0]    my_q, my_d;
  logic             res_pv_q, res_pv_d, m_pv_q, m_pv_d;
  logic [XW-1:0]    res_x_q, res_x_d, m_x_q, m_x_d;
  logic [YW-1:0]    res_y_q, res_y_d, m_y_q, m_y_d;

  logic div_start;
  logic in_xfer, out_xfer;

  tpcs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  tpcs_div #(
    .DW (DW),
    .DVW(RAW_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q[DW-1:0]),
    .divisor_i (divisor_q),
    .quotient_o(quot),
    .stat_o    (div_stat)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = m_valid_q && m_axis_tready;
  assign div_start     = (state_q == S_DGO);

  always_comb begin
    logic [RAW_W-1:0]   raw_sel, lo_sel, hi_sel, adiff, aspan;
    logic [RAW_W:0]     diff, span;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic signed [VW-1:0] qs, v, lim;
    logic [MW-1:0]      map_val;
    logic [SXW-1:0]     avg_x_full;
    logic [SYW-1:0]     avg_y_full;
    logic [XW-1:0]      avg_x, fx;
    logic [YW-1:0]      avg_y, fy;
    logic [XW:0]        ddx, adx;
    logic [YW:0]        ddy, ady;
    logic               jump;
    logic [1:0]         cnt_n;

    state_d    = state_q;
    axis_d     = axis_q;
    cnt_d      = cnt_q;
    sum_x_d    = sum_x_q;
    sum_y_d    = sum_y_q;
    reported_d = reported_q;
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    m_valid_d  = m_valid_q;
    raw_x_d    = raw_x_q;
    raw_y_d    = raw_y_q;
    prod_d     = prod_q;
    neg_d      = neg_q;
    narrow_d   = narrow_q;
    divisor_d  = divisor_q;
    mx_d       = mx_q;
    my_d       = my_q;
    sx_d       = sx_q;
    res_pv_d   = res_pv_q;
    res_x_d    = res_x_q;
    res_y_d    = res_y_q;
    m_pv_d     = m_pv_q;
    m_x_d      = m_x_q;
    m_y_d      = m_y_q;

    // axis operands for the linear map
    raw_sel = axis_q ? raw_y_q : raw_x_q;
    lo_sel  = axis_q ? cfg.cal_top : cfg.cal_left;
    hi_sel  = axis_q ? cfg.cal_bottom : cfg.cal_right;
    diff    = {1'b0, raw_sel} - {1'b0, lo_sel};
    span    = {1'b0, hi_sel} - {1'b0, lo_sel};
    adiff   = diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
    aspan   = span[RAW_W] ? RAW_W'(-span) : span[RAW_W-1:0];

    // shared multiplier: span product or reciprocal of three
    if (state_q == S_AMUL) begin
      mul_a = axis_q ? MUL_A_W'(sum_y_q) : MUL_A_W'(sum_x_q);
      mul_b = MUL_B_W'(RECIP3);
    end else begin
      mul_a = MUL_A_W'(adiff);
      mul_b = axis_q ? MUL_B_W'(TY) : MUL_B_W'(TX);
    end

    // margin plus signed quotient, clamped to the screen; a narrow span maps to the margin
    qs  = signed'({2'b00, quot});
    v   = signed'(VW'(EDGE_MARGIN)) + (neg_q ? -qs : qs);
    lim = axis_q ? signed'(VW'(SCREEN_HEIGHT - 1)) : signed'(VW'(SCREEN_WIDTH - 1));
    if (narrow_q) begin
      map_val = MW'(EDGE_MARGIN);
    end else if (v[VW-1]) begin
      map_val = '0;
    end else if (v > lim) begin
      map_val = lim[MW-1:0];
    end else begin
      map_val = v[MW-1:0];
    end

    // running average of up to two samples
    avg_x_full = cnt_q[1] ? (sum_x_q >> 1) : sum_x_q;
    avg_y_full = cnt_q[1] ? (sum_y_q >> 1) : sum_y_q;
    avg_x      = avg_x_full[XW-1:0];
    avg_y      = avg_y_full[YW-1:0];
    ddx        = {1'b0, mx_q} - {1'b0, avg_x};
    ddy        = {1'b0, my_q} - {1'b0, avg_y};
    adx        = ddx[XW] ? -ddx : ddx;
    ady        = ddy[YW] ? -ddy : ddy;
    jump       = (cnt_q != 2'd0) &&
                 ((adx > (XW+1)'(SETTLE_TOL)) || (ady > (YW+1)'(SETTLE_TOL)));
    cnt_n      = (jump ? 2'd0 : cnt_q) + 2'd1;

    // final average and optional half turn
    fx = cfg.flip ? XW'(SCREEN_WIDTH - 1) - sx_q : sx_q;
    fy = cfg.flip ? YW'(SCREEN_HEIGHT - 1) - prod_q[RECIP3_SHIFT +: YW]
                  : prod_q[RECIP3_SHIFT +: YW];

    if (out_xfer) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          raw_x_d  = s_axis_tdata[RAW_W-1:0];
          raw_y_d  = s_axis_tdata[2*RAW_W-1:RAW_W];
          res_pv_d = 1'b0;
          res_x_d  = '0;
          res_y_d  = '0;
          state_d  = S_OUT;
          if (!s_axis_tuser) begin
            // release
            cnt_d      = 2'd0;
            sum_x_d    = '0;
            sum_y_d    = '0;
            reported_d = 1'b0;
          end else if (reported_q) begin
            res_pv_d = 1'b1;
            res_x_d  = held_x_q;
            res_y_d  = held_y_q;
          end else if (s_axis_tdata[3*RAW_W-1:2*RAW_W] >= {5'd0, cfg.press_thr}) begin
            axis_d  = 1'b0;
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d    = mul_a * mul_b;
        neg_d     = diff[RAW_W] ^ span[RAW_W];
        narrow_d  = aspan < RAW_W'(MIN_SPAN);
        divisor_d = aspan;
        state_d   = S_DGO;
      end
      S_DGO: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (axis_q) begin
            my_d    = map_val[YW-1:0];
            state_d = S_CMP;
          end else begin
            mx_d    = map_val[XW-1:0];
            axis_d  = 1'b1;
            state_d = S_MUL;
          end
        end
      end
      S_CMP: begin
        sum_x_d  = (jump ? '0 : sum_x_q) + SXW'(mx_q);
        sum_y_d  = (jump ? '0 : sum_y_q) + SYW'(my_q);
        cnt_d    = cnt_n;
        axis_d   = 1'b0;
        res_pv_d = 1'b0;
        res_x_d  = '0;
        res_y_d  = '0;
        state_d  = (cnt_n == 2'(SETTLE_NEED)) ? S_AMUL : S_OUT;
      end
      S_AMUL: begin
        prod_d  = mul_a * mul_b;
        state_d = S_AVG;
      end
      S_AVG: begin
        if (axis_q) begin
          held_x_d   = fx;
          held_y_d   = fy;
          reported_d = 1'b1;
          res_pv_d   = 1'b1;
          res_x_d    = fx;
          res_y_d    = fy;
          state_d    = S_OUT;
        end else begin
          sx_d    = prod_q[RECIP3_SHIFT +: XW];
          axis_d  = 1'b1;
          state_d = S_AMUL;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_pv_d    = res_pv_q;
          m_x_d     = res_x_q;
          m_y_d     = res_y_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      axis_q     <= 1'b0;
      cnt_q      <= 2'd0;
      sum_x_q    <= '0;
      sum_y_q    <= '0;
      reported_q <= 1'b0;
      held_x_q   <= '0;
      held_y_q   <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      axis_q     <= axis_d;
      cnt_q      <= cnt_d;
      sum_x_q    <= sum_x_d;
      sum_y_q    <= sum_y_d;
      reported_q <= reported_d;
      held_x_q   <= held_x_d;
      held_y_q   <= held_y_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_x_q   <= raw_x_d;
    raw_y_q   <= raw_y_d;
    prod_q    <= prod_d;
    neg_q     <= neg_d;
    narrow_q  <= narrow_d;
    divisor_q <= divisor_d;
    mx_q      <= mx_d;
    my_q      <= my_d;
    sx_q      <= sx_d;
    res_pv_q  <= res_pv_d;
    res_x_q   <= res_x_d;
    res_y_q   <= res_y_d;
    m_pv_q    <= m_pv_d;
    m_x_q     <= m_x_d;
    m_y_q     <= m_y_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_pv_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_y_q, m_x_q});

  a_reported_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    reported_q |-> (cnt_q == 2'(SETTLE_NEED)))
    else $error("point latched without a full settle run");
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while a sample is in work");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("position not zero on an invalid result");
  a_div_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside its wait state");

endmodule

### tb/tb_touch_point_calibrate_and_settle_unit.sv
// self-checking testbench of the touch point calibrate and settle unit
`timescale 1ns / 1ps

module tb_touch_point_calibrate_and_settle_unit;
  import tpcs_pkg::*;

  localparam int XW          = $clog2(DEF_SCREEN_WIDTH);
  localparam int YW          = $clog2(DEF_SCREEN_HEIGHT);
  localparam int OUT_W       = ((XW + YW + 7) / 8) * 8;
  localparam int N_SETTINGS  = 8;
  localparam int PER_SETTING = 64;
  localparam int HOLD_AT     = 150;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN       = 40;
  localparam int IDLE_LIMIT  = 2000;
  localparam int N_ROWS      = 22;

  // indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic             touched;
    logic [RAW_W-1:0] x;
    logic [RAW_W-1:0] y;
    logic [RAW_W-1:0] p;
  } sample_t;

  typedef struct packed {
    logic          valid;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } point_t;

  typedef struct packed {
    logic             touched;
    logic [RAW_W-1:0] x;
    logic [RAW_W-1:0] y;
    logic [RAW_W-1:0] p;
    logic             typed;
    logic             want_v;
    logic [XW-1:0]    want_x;
    logic [YW-1:0]    want_y;
  } row_t;

  // directed samples at the reset calibration; typed rows carry their expected point
  localparam row_t DIR_ROWS [N_ROWS] = '{
    '{0, 0, 0, 0, 1, 0, 0, 0},                // release straight after reset
    '{1, 4095, 4095, 119, 1, 0, 0, 0},        // one below the pressure threshold
    '{1, 0, 0, 120, 1, 0, 0, 0},              // exactly at the threshold
    '{1, 0, 0, 4095, 1, 0, 0, 0},
    '{1, 0, 0, 4095, 1, 1, 24, 24},           // third sample settles at the margin
    '{1, 4095, 4095, 0, 1, 1, 24, 24},        // held contact repeats the latch
    '{0, 4095, 4095, 4095, 1, 0, 0, 0},
    '{1, 4095, 4095, 4095, 1, 0, 0, 0},
    '{1, 4095, 4095, 4095, 1, 0, 0, 0},
    '{1, 4095, 4095, 4095, 1, 1, 295, 215},   // far corner
    '{1, 0, 0, 0, 1, 1, 295, 215},
    '{0, 0, 0, 0, 1, 0, 0, 0},
    '{1, 2048, 2048, 200, 0, 0, 0, 0},
    '{1, 0, 0, 200, 0, 0, 0, 0},              // jump restarts the average
    '{1, 0, 0, 200, 0, 0, 0, 0},
    '{1, 0, 0, 200, 0, 0, 0, 0},
    '{0, 1234, 2345, 3456, 1, 0, 0, 0},
    '{1, 1000, 1000, 300, 0, 0, 0, 0},
    '{1, 1250, 1250, 300, 0, 0, 0, 0},        // drift inside the tolerance
    '{1, 1530, 1530, 300, 0, 0, 0, 0},
    '{1, 1530, 1530, 300, 0, 0, 0, 0},
    '{0, 4095, 0, 4095, 1, 0, 0, 0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // calibration copy and settle state of the predictor
  logic [RAW_W-1:0] cal_l, cal_r, cal_t, cal_b;
  logic [THR_W-1:0] cfg_thr;
  logic             cfg_flip;
  int               settle_n, acc_x, acc_y;
  logic             latched;
  logic [XW-1:0]    hold_x;
  logic [YW-1:0]    hold_y;

  point_t point_q [$];
  bit     burst;
  int     mismatches, n_samples, n_active, n_results, n_points, n_settings;

  touch_point_calibrate_and_settle_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int axis_to_screen(int raw, int lo, int hi, int size);
    int span, aspan, v;
    span  = hi - lo;
    aspan = (span < 0) ? -span : span;
    if (aspan < MIN_SPAN) return DEF_EDGE_MARGIN;
    // signed division truncates toward zero
    v = DEF_EDGE_MARGIN + (raw - lo) * (size - 1 - 2 * DEF_EDGE_MARGIN) / span;
    if (v < 0) v = 0;
    if (v > size - 1) v = size - 1;
    return v;
  endfunction

  function automatic point_t predict_point(sample_t s);
    point_t r;
    int     mx, my, dx, dy, sx, sy;
    r = '0;
    if (!s.touched) begin
      settle_n = 0;
      acc_x    = 0;
      acc_y    = 0;
      latched  = 1'b0;
      n_active++;
      return r;
    end
    if (latched) begin
      r.valid = 1'b1;
      r.x     = hold_x;
      r.y     = hold_y;
      return r;
    end
    if (s.p < cfg_thr) return r;
    n_active++;
    mx = axis_to_screen(s.x, cal_l, cal_r, DEF_SCREEN_WIDTH);
    my = axis_to_screen(s.y, cal_t, cal_b, DEF_SCREEN_HEIGHT);
    if (settle_n != 0) begin
      dx = mx - acc_x / settle_n;
      dy = my - acc_y / settle_n;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      if (dx > SETTLE_TOL || dy > SETTLE_TOL) begin
        settle_n = 0;
        acc_x    = 0;
        acc_y    = 0;
      end
    end
    acc_x += mx;
    acc_y += my;
    settle_n++;
    if (settle_n < SETTLE_NEED) return r;
    sx = acc_x / settle_n;
    sy = acc_y / settle_n;
    if (cfg_flip) begin
      sx = DEF_SCREEN_WIDTH - 1 - sx;
      sy = DEF_SCREEN_HEIGHT - 1 - sy;
    end
    hold_x  = XW'(sx);
    hold_y  = YW'(sy);
    latched = 1'b1;
    r.valid = 1'b1;
    r.x     = hold_x;
    r.y     = hold_y;
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    = 1'b1;
    cfg_addr_i  = addr;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (addr)
      REG_CAL_LEFT:   cal_l = data;
      REG_CAL_RIGHT:  cal_r = data;
      REG_CAL_TOP:    cal_t = data;
      REG_CAL_BOTTOM: cal_b = data;
      REG_PRESS_THR:  cfg_thr = data[THR_W-1:0];
      REG_FLIP:       cfg_flip = data[0];
      default: ;
    endcase
  endtask

  // one transfer on the sample side; the point predicted at acceptance, or a typed row's expected point, is queued
  task automatic send_sample(input sample_t s, input bit typed, input point_t want);
    int     gap;
    point_t p;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = s.touched;
    s_axis_tdata  = {{(IN_TDATA_W - 3 * RAW_W){1'b0}}, s.p, s.y, s.x};
    do @(posedge clk_i); while (!s_axis_tready);
    p = predict_point(s);
    point_q.push_back(typed ? want : p);
    n_samples++;
    @(negedge clk_i);
  endtask

  task automatic drain_points();
    s_axis_tvalid = 1'b0;
    while (point_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [RAW_W-1:0] nudge(int base);
    int span, v;
    span = $urandom_range(0, 1) ? 40 : 320;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return RAW_W'(v);
  endfunction

  // a well-formed contact: a few samples around a spot that may jump now and then, then a release
  task automatic run_contact();
    int      len, bx, by, i;
    sample_t s;
    bx  = $urandom_range(0, 4095);
    by  = $urandom_range(0, 4095);
    len = $urandom_range(3, 7);
    s.touched = 1'b1;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) bx = $urandom_range(0, 4095);
      if ($urandom_range(0, 19) == 0) by = $urandom_range(0, 4095);
      s.x = nudge(bx);
      s.y = nudge(by);
      if ($urandom_range(0, 7) == 0) s.p = RAW_W'($urandom_range(0, cfg_thr - 1));
      else s.p = RAW_W'($urandom_range(cfg_thr, 4095));
      send_sample(s, 1'b0, '0);
    end
    s.touched = 1'b0;
    s.x = RAW_W'($urandom_range(0, 4095));
    s.y = RAW_W'($urandom_range(0, 4095));
    s.p = RAW_W'($urandom_range(0, 4095));
    send_sample(s, 1'b0, '0);
  endtask

  task automatic apply_setting(int k);
    logic [RAW_W-1:0]      l, r, t, b;
    logic [THR_W-1:0]      th;
    logic                  f;
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    case (k)
      1: begin l = 200;  r = 3900; t = 300;  b = 3800; th = 12;  f = 1'b1; end
      2: begin l = 3900; r = 200;  t = 3800; b = 300;  th = 120; f = 1'b0; end
      // x span just under the minimum, y span exactly at it
      3: begin l = 1000; r = 1099; t = 2000; b = 2100; th = 64;  f = 1'b1; end
      4: begin l = 4095; r = 0;    t = 4095; b = 0;    th = 12;  f = 1'b0; end
      5: begin l = 0;    r = 4095; t = 0;    b = 4095; th = 120; f = 1'b1; end
      6: begin l = 2100; r = 2000; t = 1099; b = 1000; th = 100; f = 1'b0; end
      default: begin
        l  = RAW_W'($urandom_range(0, 4095));
        r  = RAW_W'($urandom_range(0, 4095));
        t  = RAW_W'($urandom_range(0, 4095));
        b  = RAW_W'($urandom_range(0, 4095));
        th = THR_W'($urandom_range(12, 120));
        f  = 1'($urandom_range(0, 1));
      end
    endcase
    write_reg(REG_CAL_LEFT, l);
    write_reg(REG_CAL_RIGHT, r);
    write_reg(REG_CAL_TOP, t);
    write_reg(REG_CAL_BOTTOM, b);
    // unused upper bits of the narrow registers carry junk
    write_reg(REG_PRESS_THR, {junk[CFG_DATA_W-1:THR_W], th});
    write_reg(REG_FLIP, {junk[CFG_DATA_W-2:0], f});
    write_reg(REG_SPARE_A, junk);
    write_reg(REG_SPARE_B, ~junk);
    n_settings++;
  endtask

  initial begin
    int      k, i;
    sample_t s;
    point_t  want;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tvalid = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    cal_l    = RST_CAL_LO;
    cal_r    = RST_CAL_HI;
    cal_t    = RST_CAL_LO;
    cal_b    = RST_CAL_HI;
    cfg_thr  = RST_PRESS_THR;
    cfg_flip = 1'b0;
    settle_n = 0;
    acc_x    = 0;
    acc_y    = 0;
    latched  = 1'b0;
    hold_x   = '0;
    hold_y   = '0;
    burst    = 1'b0;
    n_settings = 1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (i = 0; i < N_ROWS; i++) begin
      s.touched = DIR_ROWS[i].touched;
      s.x       = DIR_ROWS[i].x;
      s.y       = DIR_ROWS[i].y;
      s.p       = DIR_ROWS[i].p;
      want.valid = DIR_ROWS[i].want_v;
      want.x     = DIR_ROWS[i].want_x;
      want.y     = DIR_ROWS[i].want_y;
      send_sample(s, DIR_ROWS[i].typed, want);
    end

    for (k = 0; k < N_SETTINGS; k++) begin
      if (k != 0) begin
        drain_points();
        apply_setting(k);
      end
      while (n_samples < N_ROWS + (k + 1) * PER_SETTING) begin
        // occasional stretches with neither side idling
        burst = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 4) != 0) begin
          run_contact();
        end else begin
          s.touched = 1'($urandom_range(0, 1));
          s.x = RAW_W'($urandom_range(0, 4095));
          s.y = RAW_W'($urandom_range(0, 4095));
          s.p = RAW_W'($urandom_range(0, 4095));
          send_sample(s, 1'b0, '0);
        end
      end
    end

    drain_points();
    $display("%0d samples sent (%0d release or qualifying) across %0d calibration settings",
             n_samples, n_active, n_settings);
    $display("%0d results checked, %0d of them carrying a settled point", n_results, n_points);
    if (mismatches == 0) begin
      $display("touch_point_calibrate_and_settle_unit: match");
    end else begin
      $display("touch_point_calibrate_and_settle_unit: mismatch");
    end
    $finish;
  end

  // point side: random stalls, plus one long hold-off that backs up the sample side
  initial begin
    int  stall;
    bit  long_done;
    long_done     = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 14);
      if (!long_done && n_results >= HOLD_AT) begin
        stall     = LONG_HOLD;
        long_done = 1'b1;
      end
      if (stall != 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_points
    point_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (m_axis_tuser) n_points++;
      if (point_q.size() == 0) begin
        $error("unexpected transfer: point_valid %0b pos_x %0d pos_y %0d",
               m_axis_tuser, m_axis_tdata[XW-1:0], m_axis_tdata[XW+YW-1:XW]);
        mismatches++;
      end else begin
        want = point_q.pop_front();
        if (m_axis_tuser !== want.valid) begin
          $error("point_valid: expected %0b, got %0b", want.valid, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[XW-1:0] !== want.x) begin
          $error("pos_x: expected %0d, got %0d", want.x, m_axis_tdata[XW-1:0]);
          mismatches++;
        end
        if (m_axis_tdata[XW+YW-1:XW] !== want.y) begin
          $error("pos_y: expected %0d, got %0d", want.y, m_axis_tdata[XW+YW-1:XW]);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
    end
    $display("timeout after %0d cycles without a transfer, %0d points outstanding",
             IDLE_LIMIT, point_q.size());
    $display("touch_point_calibrate_and_settle_unit: mismatch");
    $finish;
  end

endmodule

### touch_point_calibrate_and_settle_unit.f
sv/tpcs_pkg.sv
sv/tpcs_cfg.sv
sv/tpcs_div.sv
sv/touch_point_calibrate_and_settle_unit.sv
tb/tb_touch_point_calibrate_and_settle_unit.sv
